@@ sv/stt_pkg.sv @@
`timescale 1ns / 1ps

package stt_pkg;

    // Table geometry
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int HIT_W           = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int ID_W     = 32;
    localparam int TICK_W   = 64;
    localparam int DELAY_W  = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_CREATED   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_CANCELLED = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STS_EXPIRED   = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NO_EXPIRY = 3'd5;

    // One result handed from the engine to the output register
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [TICK_W-1:0]   now;
        logic                last;
    } stt_push_t;

endpackage

@@ sv/stt_engine.sv @@
`timescale 1ns / 1ps

module stt_engine #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stt_pkg::REQ_W-1:0]     req_type,
    input  logic [stt_pkg::DELAY_W-1:0]   delay,
    input  logic                          repeat_req,
    input  logic [stt_pkg::ID_W-1:0]      cancel_id,
    input  logic                          out_free,
    output logic                          idle,
    output stt_pkg::stt_push_t            push
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [stt_pkg::REQ_W-1:0]      req_reg;
    logic [stt_pkg::DELAY_W-1:0]    delay_reg;
    logic                           rep_reg;
    logic [stt_pkg::ID_W-1:0]       cid_reg;
    logic [stt_pkg::TICK_W-1:0]     tick_reg;
    logic [stt_pkg::ID_W-1:0]       next_id_reg;
    logic [stt_pkg::ID_W-1:0]       next_id_next;
    logic [TIMER_SLOTS-1:0]         used_reg;
    logic [CNT_W-1:0]               addr_reg;
    logic                           chk_valid_reg;
    logic [IDX_W-1:0]               chk_idx_reg;
    logic                           pend_valid_reg;
    logic [stt_pkg::ID_W-1:0]       pend_id_reg;
    logic [stt_pkg::HIT_W-1:0]      hit_cnt_reg;
    logic [stt_pkg::STATUS_W-1:0]   fin_status_reg;
    logic [stt_pkg::ID_W-1:0]       fin_id_reg;

    // Slot store and its registered read port
    logic [stt_pkg::ID_W-1:0]       id_mem  [TIMER_SLOTS];
    logic [stt_pkg::TICK_W-1:0]     dl_mem  [TIMER_SLOTS];
    logic [stt_pkg::DELAY_W-1:0]    per_mem [TIMER_SLOTS];
    logic                           rep_mem [TIMER_SLOTS];
    logic [stt_pkg::ID_W-1:0]       rd_id_reg;
    logic [stt_pkg::TICK_W-1:0]     rd_dl_reg;
    logic [stt_pkg::DELAY_W-1:0]    rd_per_reg;
    logic                           rd_rep_reg;

    logic                           is_tick;
    logic                           is_create;
    logic                           is_cancel;
    logic                           chk_used;
    logic                           hit;
    logic                           hit_q;
    logic                           stall;
    logic                           advance;
    logic                           issue;
    logic                           last_chk;
    logic [stt_pkg::DELAY_W-1:0]    add_b;
    logic [stt_pkg::TICK_W-1:0]     wr_dl;
    logic                           we_all;
    logic                           we_dl;

    assign is_tick   = (req_reg == stt_pkg::REQ_TICK);
    assign is_create = (req_reg == stt_pkg::REQ_CREATE);
    assign is_cancel = (req_reg == stt_pkg::REQ_CANCEL);
    assign chk_used  = used_reg[chk_idx_reg];
    assign last_chk  = (chk_idx_reg == IDX_W'(TIMER_SLOTS - 1));
    assign idle      = (state_reg == ST_IDLE);

    // Decide whether the slot under check matches the request
    always_comb
    begin
        case (req_reg)
            stt_pkg::REQ_CREATE: hit = !chk_used;
            stt_pkg::REQ_CANCEL: hit = chk_used && (rd_id_reg == cid_reg);
            stt_pkg::REQ_TICK:   hit = chk_used && (tick_reg >= rd_dl_reg)
                                       && (hit_cnt_reg < stt_pkg::HIT_W'(stt_pkg::MAX_RESULTS));
            default:             hit = 1'b0;
        endcase
    end

    assign hit_q   = chk_valid_reg && hit;
    // Hold the scan when a second expiry needs the output and it is busy
    assign stall   = hit_q && is_tick && pend_valid_reg && !out_free;
    assign advance = (state_reg == ST_SCAN) && !stall;
    assign issue   = advance && (addr_reg < CNT_W'(TIMER_SLOTS))
                     && !(hit_q && !is_tick);

    // Shared deadline adder: create uses the delay, rearm uses the period
    assign add_b  = is_create ? delay_reg : rd_per_reg;
    assign wr_dl  = tick_reg + {{(stt_pkg::TICK_W - stt_pkg::DELAY_W){1'b0}}, add_b};
    assign we_all = advance && hit_q && is_create;
    assign we_dl  = advance && hit_q && (is_create || (is_tick && rd_rep_reg));

    // Wrap the id counter and skip zero
    always_comb
    begin
        next_id_next = next_id_reg + 32'd1;
        if (next_id_next == '0)
        begin
            next_id_next = 32'd1;
        end
    end

    // Build the result beat
    always_comb
    begin
        push        = '0;
        push.now    = tick_reg;
        if (advance && hit_q && is_tick && pend_valid_reg)
        begin
            push.valid  = 1'b1;
            push.status = stt_pkg::STS_EXPIRED;
            push.id     = pend_id_reg;
            push.last   = 1'b0;
        end
        else if ((state_reg == ST_FINISH) && out_free)
        begin
            push.valid = 1'b1;
            push.last  = 1'b1;
            if (is_tick)
            begin
                push.status = pend_valid_reg ? stt_pkg::STS_EXPIRED : stt_pkg::STS_NO_EXPIRY;
                push.id     = pend_valid_reg ? pend_id_reg : '0;
            end
            else
            begin
                push.status = fin_status_reg;
                push.id     = fin_id_reg;
            end
        end
    end

    // Write and read the slot store
    always_ff @(posedge clk)
    begin
        if (we_all)
        begin
            id_mem[chk_idx_reg]  <= next_id_reg;
            per_mem[chk_idx_reg] <= delay_reg;
            rep_mem[chk_idx_reg] <= rep_reg;
        end
        if (we_dl)
        begin
            dl_mem[chk_idx_reg] <= wr_dl;
        end
        if (issue)
        begin
            rd_id_reg  <= id_mem[addr_reg[IDX_W-1:0]];
            rd_dl_reg  <= dl_mem[addr_reg[IDX_W-1:0]];
            rd_per_reg <= per_mem[addr_reg[IDX_W-1:0]];
            rd_rep_reg <= rep_mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_reg        <= stt_pkg::REQ_TICK;
            delay_reg      <= '0;
            rep_reg        <= 1'b0;
            cid_reg        <= '0;
            tick_reg       <= '0;
            next_id_reg    <= 32'd1;
            used_reg       <= '0;
            addr_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_id_reg    <= '0;
            hit_cnt_reg    <= '0;
            fin_status_reg <= stt_pkg::STS_CREATED;
            fin_id_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg        <= req_type;
                        delay_reg      <= delay;
                        rep_reg        <= repeat_req;
                        cid_reg        <= cancel_id;
                        addr_reg       <= '0;
                        chk_valid_reg  <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        hit_cnt_reg    <= '0;
                        // Unused request code still loads the request registers but stays idle
                        if (req_type == stt_pkg::REQ_TICK)
                        begin
                            tick_reg  <= tick_reg + 64'd1;
                            state_reg <= ST_SCAN;
                        end
                        else if ((req_type == stt_pkg::REQ_CREATE) ||
                                 (req_type == stt_pkg::REQ_CANCEL))
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (advance)
                    begin
                        // Advance the read pipeline one slot
                        if (issue)
                        begin
                            chk_valid_reg <= 1'b1;
                            chk_idx_reg   <= addr_reg[IDX_W-1:0];
                            addr_reg      <= addr_reg + CNT_W'(1);
                        end
                        else
                        begin
                            chk_valid_reg <= 1'b0;
                        end

                        if (hit_q && is_create)
                        begin
                            used_reg[chk_idx_reg] <= 1'b1;
                            next_id_reg           <= next_id_next;
                            fin_status_reg        <= stt_pkg::STS_CREATED;
                            fin_id_reg            <= next_id_reg;
                            state_reg             <= ST_FINISH;
                        end
                        else if (hit_q && is_cancel)
                        begin
                            used_reg[chk_idx_reg] <= 1'b0;
                            fin_status_reg        <= stt_pkg::STS_CANCELLED;
                            fin_id_reg            <= cid_reg;
                            state_reg             <= ST_FINISH;
                        end
                        else
                        begin
                            // Hold one expiry back so the final one gets last
                            if (hit_q && is_tick)
                            begin
                                pend_valid_reg <= 1'b1;
                                pend_id_reg    <= rd_id_reg;
                                hit_cnt_reg    <= hit_cnt_reg + stt_pkg::HIT_W'(1);
                                if (!rd_rep_reg)
                                begin
                                    used_reg[chk_idx_reg] <= 1'b0;
                                end
                            end
                            if (chk_valid_reg && last_chk)
                            begin
                                fin_status_reg <= is_create ? stt_pkg::STS_FULL
                                                            : stt_pkg::STS_NOT_FOUND;
                                fin_id_reg     <= '0;
                                state_reg      <= ST_FINISH;
                            end
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pend_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_SCAN || state_reg == ST_FINISH))
        else $error("pending expiry outside a tick scan");

    a_hit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= stt_pkg::HIT_W'(stt_pkg::MAX_RESULTS))
        else $error("expiry count above the per-tick limit");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_free)
        else $error("result beat pushed into a busy output register");

    a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && idle && req_type == stt_pkg::REQ_TICK)
        |=> (tick_reg == $past(tick_reg) + 64'd1) && (state_reg == ST_SCAN))
        else $error("tick request did not advance the counter");
`endif

endmodule

@@ sv/software_timer_table_unit.sv @@
`timescale 1ns / 1ps
// Flow: a request walks the slot store one slot per cycle unless the scan stalls on a busy
//   output register; create and cancel stop at their slot.
// Accept: s_tready is high only while the sequencer is idle, and a tick with several
//   expiries also waits for each result beat to leave the output register.
// Reset: rst_n clears the tick counter, the id counter (to one) and all slot-used bits at once.

module software_timer_table_unit #(
    parameter int TIMER_SLOTS = stt_pkg::TIMER_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // delay[31:0], repeat_req[32], cancel_id[64:33], zero pad
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // result_id[31:0], now[95:32]
    output logic [2:0]   m_tuser,   // status[2:0]
    output logic         m_tlast    // last
);

    stt_pkg::stt_push_t              push;
    logic                            idle;
    logic                            out_free;
    logic                            m_tvalid_reg;
    logic [stt_pkg::STATUS_W-1:0]    m_status_reg;
    logic [stt_pkg::ID_W-1:0]        m_id_reg;
    logic [stt_pkg::TICK_W-1:0]      m_now_reg;
    logic                            m_last_reg;

    assign s_tready = idle;
    assign out_free = !m_tvalid_reg || m_tready;

    stt_engine #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_tvalid && idle),
        .req_type   (s_tuser),
        .delay      (s_tdata[31:0]),
        .repeat_req (s_tdata[32]),
        .cancel_id  (s_tdata[64:33]),
        .out_free   (out_free),
        .idle       (idle),
        .push       (push)
    );

    // Hold the result beat until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            m_status_reg <= push.status;
            m_id_reg     <= push.id;
            m_now_reg    <= push.now;
            m_last_reg   <= push.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_now_reg, m_id_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule
